@@ design/bitbang_spi_master_byte_core_macros.svh @@
// ----------------------------------------------------------------------------
// SPI master assertion macros
// Shared concurrent assertion forms for the byte SPI master.
// ----------------------------------------------------------------------------
`ifndef BITBANG_SPI_MASTER_BYTE_CORE_MACROS_SVH
`define BITBANG_SPI_MASTER_BYTE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle assertion failed.");

// The consequent must hold in the cycle after the antecedent.
`define BSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle assertion failed.");

`endif

@@ design/bsm_pkg.sv @@
// ----------------------------------------------------------------------------
// SPI master package
// Types, constants and register indexes shared by the byte SPI master.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsm_pkg;

    localparam int BYTE_BITS  = 8;
    localparam int BIT_CNT_W  = $clog2(BYTE_BITS);
    localparam int HALF_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = HALF_W;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(BYTE_BITS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_CPOL        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CPHA        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LSB_FIRST   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd3;

    localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd1;

    typedef struct packed {
        logic              cpol;
        logic              cpha;
        logic              lsb_first;
        logic [HALF_W-1:0] half_period;
    } cfg_t;

    typedef struct packed {
        logic                 start_req;
        logic [BYTE_BITS-1:0] tx_byte;
        logic                 miso_level;
        logic                 tick_enable;
    } item_t;

    typedef struct packed {
        logic                 sck_level;
        logic                 mosi_level;
        logic                 busy_res;
        logic                 byte_done;
        logic [BYTE_BITS-1:0] rx_byte;
    } result_t;

endpackage

@@ design/bsm_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// SPI master configuration registers
// Holds clock polarity, phase, bit order and half-period length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsm_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [bsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsm_pkg::CFG_DATA_W-1:0] cfg_data,
    output bsm_pkg::cfg_t                  cfg
);

    bsm_pkg::cfg_t cfg_reg;
    bsm_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                bsm_pkg::CFG_CPOL:        cfg_next.cpol        = cfg_data[0];
                bsm_pkg::CFG_CPHA:        cfg_next.cpha        = cfg_data[0];
                bsm_pkg::CFG_LSB_FIRST:   cfg_next.lsb_first   = cfg_data[0];
                bsm_pkg::CFG_HALF_PERIOD: cfg_next.half_period = cfg_data;
                default:                  cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cpol        <= 1'b0;
            cfg_reg.cpha        <= 1'b0;
            cfg_reg.lsb_first   <= 1'b0;
            cfg_reg.half_period <= bsm_pkg::HALF_PERIOD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/bsm_engine.sv @@
// ----------------------------------------------------------------------------
// SPI master bit engine
// Holds the exchange state and advances it by one clock tick per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsm_engine
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  bsm_pkg::cfg_t    cfg,
    input  bsm_pkg::item_t   item,
    output bsm_pkg::result_t result
);

    logic [bsm_pkg::HALF_W-1:0]    half_counter_reg;
    logic [bsm_pkg::HALF_W-1:0]    half_counter_next;
    logic [bsm_pkg::BIT_CNT_W-1:0] bit_count_reg;
    logic [bsm_pkg::BIT_CNT_W-1:0] bit_count_next;
    logic                          second_half_reg;
    logic                          second_half_next;
    logic [bsm_pkg::BYTE_BITS-1:0] tx_shifter_reg;
    logic [bsm_pkg::BYTE_BITS-1:0] tx_shifter_next;
    logic [bsm_pkg::BYTE_BITS-1:0] rx_shifter_reg;
    logic [bsm_pkg::BYTE_BITS-1:0] rx_shifter_next;
    logic                          active_reg;
    logic                          active_next;
    logic                          clock_out_reg;
    logic                          clock_out_next;
    logic                          data_out_reg;
    logic                          data_out_next;

    logic [bsm_pkg::HALF_W:0]      limit;
    logic [bsm_pkg::HALF_W:0]      count_inc;
    logic                          first_level;
    logic                          done;
    logic [bsm_pkg::BYTE_BITS-1:0] rx_out;

    always_comb
    begin
        limit       = (cfg.half_period == '0) ? (bsm_pkg::HALF_W + 1)'(1)
                                              : {1'b0, cfg.half_period};
        count_inc   = {1'b0, half_counter_reg} + (bsm_pkg::HALF_W + 1)'(1);
        first_level = cfg.cpol ^ cfg.cpha;

        half_counter_next = half_counter_reg;
        bit_count_next    = bit_count_reg;
        second_half_next  = second_half_reg;
        tx_shifter_next   = tx_shifter_reg;
        rx_shifter_next   = rx_shifter_reg;
        active_next       = active_reg;
        clock_out_next    = clock_out_reg;
        data_out_next     = data_out_reg;
        done              = 1'b0;
        rx_out            = '0;

        if (!active_reg)
        begin
            if (item.start_req)
            begin
                tx_shifter_next   = item.tx_byte;
                rx_shifter_next   = '0;
                bit_count_next    = '0;
                second_half_next  = 1'b0;
                half_counter_next = '0;
                active_next       = 1'b1;
                clock_out_next    = first_level;
            end
        end
        else if (item.tick_enable)
        begin
            if (count_inc >= limit)
            begin
                half_counter_next = '0;
                if (!second_half_reg)
                begin
                    // Mid-bit: drive MOSI, sample MISO and toggle SCK.
                    if (cfg.lsb_first)
                    begin
                        data_out_next   = tx_shifter_reg[0];
                        tx_shifter_next = {1'b0, tx_shifter_reg[bsm_pkg::BYTE_BITS-1:1]};
                        rx_shifter_next = {item.miso_level,
                                           rx_shifter_reg[bsm_pkg::BYTE_BITS-1:1]};
                    end
                    else
                    begin
                        data_out_next   = tx_shifter_reg[bsm_pkg::BYTE_BITS-1];
                        tx_shifter_next = {tx_shifter_reg[bsm_pkg::BYTE_BITS-2:0], 1'b0};
                        rx_shifter_next = {rx_shifter_reg[bsm_pkg::BYTE_BITS-2:0],
                                           item.miso_level};
                    end
                    clock_out_next   = ~clock_out_reg;
                    second_half_next = 1'b1;
                end
                else
                begin
                    second_half_next = 1'b0;
                    if (bit_count_reg == bsm_pkg::LAST_BIT)
                    begin
                        bit_count_next = '0;
                        active_next    = 1'b0;
                        clock_out_next = cfg.cpol;
                        done           = 1'b1;
                        rx_out         = rx_shifter_reg;
                    end
                    else
                    begin
                        bit_count_next = bit_count_reg + bsm_pkg::BIT_CNT_W'(1);
                        clock_out_next = first_level;
                    end
                end
            end
            else
            begin
                half_counter_next = count_inc[bsm_pkg::HALF_W-1:0];
            end
        end

        result.sck_level  = clock_out_next;
        result.mosi_level = data_out_next;
        result.busy_res   = active_next;
        result.byte_done  = done;
        result.rx_byte    = rx_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_counter_reg <= '0;
            bit_count_reg    <= '0;
            second_half_reg  <= 1'b0;
            tx_shifter_reg   <= '0;
            rx_shifter_reg   <= '0;
            active_reg       <= 1'b0;
            clock_out_reg    <= 1'b0;
            data_out_reg     <= 1'b0;
        end
        else if (step_en)
        begin
            half_counter_reg <= half_counter_next;
            bit_count_reg    <= bit_count_next;
            second_half_reg  <= second_half_next;
            tx_shifter_reg   <= tx_shifter_next;
            rx_shifter_reg   <= rx_shifter_next;
            active_reg       <= active_next;
            clock_out_reg    <= clock_out_next;
            data_out_reg     <= data_out_next;
        end
    end

endmodule

@@ design/bitbang_spi_master_byte_core.sv @@
// Full-duplex SPI master for one byte in modes 0 to 3. Each input word is one
// clock tick of the serial engine and produces exactly one result word giving
// SCK, MOSI, busy, done and the received byte. A word is accepted every cycle
// unless the output side stalls; its result passes through one input register,
// then the single state-update stage that writes the result register; that stage
// sets the sustained rate of one word per cycle while out_ready does not stall it.
// Each SCK half lasts max(half_period, 1) words with tick_enable high, so a byte
// spans 16 * max(half_period, 1) ticks after the start word.
// ----------------------------------------------------------------------------
// SPI master top level
// Input register, bit engine and output register with valid/ready handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "bitbang_spi_master_byte_core_macros.svh"

module bitbang_spi_master_byte_core
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_write_en,
    input  logic [bsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsm_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           start_req,
    input  logic [bsm_pkg::BYTE_BITS-1:0]  tx_byte,
    input  logic                           miso_level,
    input  logic                           tick_enable,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           sck_level,
    output logic                           mosi_level,
    output logic                           busy_res,
    output logic                           byte_done,
    output logic [bsm_pkg::BYTE_BITS-1:0]  rx_byte
);

    bsm_pkg::cfg_t    cfg;
    bsm_pkg::item_t   in_item;
    bsm_pkg::result_t step_result;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    bsm_pkg::item_t   s1_item_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    bsm_pkg::result_t out_res_reg;

    logic             advance;
    logic             step_en;
    logic             in_accept;

    assign in_item.start_req   = start_req;
    assign in_item.tx_byte     = tx_byte;
    assign in_item.miso_level  = miso_level;
    assign in_item.tick_enable = tick_enable;

    assign advance   = !out_valid_reg || out_ready;
    assign step_en   = s1_valid_reg && advance;
    assign in_ready  = !s1_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next  = in_accept ? 1'b1 : (step_en ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
    end

    bsm_cfg_regs u_cfg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    bsm_engine u_engine
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .cfg     (cfg),
        .item    (s1_item_reg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg <= in_item;
        end
        if (step_en)
        begin
            out_res_reg <= step_result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sck_level  = out_res_reg.sck_level;
    assign mosi_level = out_res_reg.mosi_level;
    assign busy_res   = out_res_reg.busy_res;
    assign byte_done  = out_res_reg.byte_done;
    assign rx_byte    = out_res_reg.rx_byte;

    `BSM_ASSERT_SAME(a_done_ends_busy, out_valid_reg && out_res_reg.byte_done, !out_res_reg.busy_res)
    `BSM_ASSERT_SAME(a_rx_only_on_done, out_valid_reg && !out_res_reg.byte_done, out_res_reg.rx_byte == '0)
    `BSM_ASSERT_NEXT(a_stage_holds, s1_valid_reg && !advance, s1_valid_reg)

endmodule

@@ verif/spi_byte_checker.sv @@
// ----------------------------------------------------------------------------
// SPI byte master checker
// Watches the configuration port and both word channels of the byte SPI
// master, predicts every result word from its own copy of the engine state,
// and compares each delivered result word field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spi_byte_checker
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_write_en,
    input  logic [bsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsm_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           start_req,
    input  logic [bsm_pkg::BYTE_BITS-1:0]  tx_byte,
    input  logic                           miso_level,
    input  logic                           tick_enable,

    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           sck_level,
    input  logic                           mosi_level,
    input  logic                           busy_res,
    input  logic                           byte_done,
    input  logic [bsm_pkg::BYTE_BITS-1:0]  rx_byte,

    output int                             mismatches,
    output int                             pending,
    output int                             bytes_done
);

    bsm_pkg::cfg_t                 spi_cfg;
    logic [bsm_pkg::HALF_W-1:0]    half_cnt;
    logic [3:0]                    bit_idx;
    logic                          in_second;
    logic [bsm_pkg::BYTE_BITS-1:0] tx_sh;
    logic [bsm_pkg::BYTE_BITS-1:0] rx_sh;
    logic                          busy_q;
    logic                          sck_q;
    logic                          mosi_q;

    bsm_pkg::result_t expected_words[$];
    bsm_pkg::item_t   seen_item;
    bsm_pkg::result_t predicted;
    bsm_pkg::result_t oldest;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task automatic spi_engine_cycle(input bsm_pkg::item_t it,
                                    output bsm_pkg::result_t res);
        logic [16:0]                   limit;
        logic [16:0]                   next_cnt;
        logic                          done;
        logic [bsm_pkg::BYTE_BITS-1:0] rx_out;
        done   = 1'b0;
        rx_out = '0;
        if (!busy_q)
        begin
            if (it.start_req)
            begin
                tx_sh     = it.tx_byte;
                rx_sh     = '0;
                bit_idx   = '0;
                in_second = 1'b0;
                half_cnt  = '0;
                busy_q    = 1'b1;
                sck_q     = (spi_cfg.cpol == spi_cfg.cpha) ? 1'b0 : 1'b1;
            end
        end
        else if (it.tick_enable)
        begin
            limit    = (spi_cfg.half_period == 0) ? 17'd1 : {1'b0, spi_cfg.half_period};
            next_cnt = {1'b0, half_cnt} + 17'd1;
            if (next_cnt >= limit)
            begin
                half_cnt = '0;
                if (!in_second)
                begin
                    if (spi_cfg.lsb_first)
                    begin
                        mosi_q = tx_sh[0];
                        tx_sh  = tx_sh >> 1;
                        rx_sh  = {it.miso_level, rx_sh[bsm_pkg::BYTE_BITS-1:1]};
                    end
                    else
                    begin
                        mosi_q = tx_sh[bsm_pkg::BYTE_BITS-1];
                        tx_sh  = tx_sh << 1;
                        rx_sh  = {rx_sh[bsm_pkg::BYTE_BITS-2:0], it.miso_level};
                    end
                    sck_q     = ~sck_q;
                    in_second = 1'b1;
                end
                else
                begin
                    in_second = 1'b0;
                    bit_idx   = bit_idx + 4'd1;
                    if (bit_idx >= bsm_pkg::BYTE_BITS)
                    begin
                        bit_idx = '0;
                        busy_q  = 1'b0;
                        sck_q   = spi_cfg.cpol;
                        done    = 1'b1;
                        rx_out  = rx_sh;
                    end
                    else
                    begin
                        sck_q = (spi_cfg.cpol == spi_cfg.cpha) ? 1'b0 : 1'b1;
                    end
                end
            end
            else
            begin
                half_cnt = next_cnt[bsm_pkg::HALF_W-1:0];
            end
        end
        res.sck_level  = sck_q;
        res.mosi_level = mosi_q;
        res.busy_res   = busy_q;
        res.byte_done  = done;
        res.rx_byte    = rx_out;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spi_cfg.cpol        = 1'b0;
            spi_cfg.cpha        = 1'b0;
            spi_cfg.lsb_first   = 1'b0;
            spi_cfg.half_period = bsm_pkg::HALF_PERIOD_RESET;
            half_cnt            = '0;
            bit_idx             = '0;
            in_second           = 1'b0;
            tx_sh               = '0;
            rx_sh               = '0;
            busy_q              = 1'b0;
            sck_q               = 1'b0;
            mosi_q              = 1'b0;
            expected_words.delete();
            mismatches          = 0;
            pending             = 0;
            bytes_done          = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    report_mismatch("result word arrived with nothing expected");
                end
                else
                begin
                    oldest = expected_words.pop_front();
                    check_field("sck_level", sck_level, oldest.sck_level);
                    check_field("mosi_level", mosi_level, oldest.mosi_level);
                    check_field("busy_res", busy_res, oldest.busy_res);
                    check_field("byte_done", byte_done, oldest.byte_done);
                    check_field("rx_byte", rx_byte, oldest.rx_byte);
                end
            end
            if (cfg_write_en)
            begin
                case (cfg_index)
                    bsm_pkg::CFG_CPOL:        spi_cfg.cpol        = cfg_data[0];
                    bsm_pkg::CFG_CPHA:        spi_cfg.cpha        = cfg_data[0];
                    bsm_pkg::CFG_LSB_FIRST:   spi_cfg.lsb_first   = cfg_data[0];
                    bsm_pkg::CFG_HALF_PERIOD: spi_cfg.half_period = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                seen_item.start_req   = start_req;
                seen_item.tx_byte     = tx_byte;
                seen_item.miso_level  = miso_level;
                seen_item.tick_enable = tick_enable;
                spi_engine_cycle(seen_item, predicted);
                expected_words.push_back(predicted);
                if (predicted.byte_done)
                    bytes_done++;
            end
            pending = expected_words.size();
        end
    end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// SPI byte master testbench
// Drives the byte SPI master with directed and random clock-tick words under
// changing SPI modes, bit orders and half periods, with idle and stall
// patterns on both channels, and leaves all checking to the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int IDLE_LIMIT = 1000;
    localparam int MIN_WORDS  = 600;
    localparam int MAX_PHASES = 40;

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           cfg_write_en = 1'b0;
    logic [bsm_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [bsm_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
    logic                           in_valid     = 1'b0;
    logic                           in_ready;
    logic                           start_req    = 1'b0;
    logic [bsm_pkg::BYTE_BITS-1:0]  tx_byte      = '0;
    logic                           miso_level   = 1'b0;
    logic                           tick_enable  = 1'b0;
    logic                           out_valid;
    logic                           out_ready    = 1'b0;
    logic                           sck_level;
    logic                           mosi_level;
    logic                           busy_res;
    logic                           byte_done;
    logic [bsm_pkg::BYTE_BITS-1:0]  rx_byte;

    int mismatches;
    int pending;
    int bytes_done;
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int words_sent    = 0;
    int idle_cycles   = 0;
    int phase;
    int rand_words;

    always #1 clk = ~clk;

    bitbang_spi_master_byte_core uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .start_req    (start_req),
        .tx_byte      (tx_byte),
        .miso_level   (miso_level),
        .tick_enable  (tick_enable),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sck_level    (sck_level),
        .mosi_level   (mosi_level),
        .busy_res     (busy_res),
        .byte_done    (byte_done),
        .rx_byte      (rx_byte)
    );

    spi_byte_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .start_req    (start_req),
        .tx_byte      (tx_byte),
        .miso_level   (miso_level),
        .tick_enable  (tick_enable),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sck_level    (sck_level),
        .mosi_level   (mosi_level),
        .busy_res     (busy_res),
        .byte_done    (byte_done),
        .rx_byte      (rx_byte),
        .mismatches   (mismatches),
        .pending      (pending),
        .bytes_done   (bytes_done)
    );

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_word(input logic s, input logic [7:0] b, input logic m,
                             input logic t);
        int  gap;
        bit  took;
        gap  = 0;
        took = 1'b0;
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        start_req   <= s;
        tx_byte     <= b;
        miso_level  <= m;
        tick_enable <= t;
        while (!took)
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        words_sent++;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    task automatic set_config(input logic pol, input logic pha, input logic lsb,
                              input logic [15:0] hp);
        cfg_write_en <= 1'b1;
        cfg_index    <= bsm_pkg::CFG_CPOL;
        cfg_data     <= {15'($urandom), pol};
        @(posedge clk);
        cfg_index    <= bsm_pkg::CFG_CPHA;
        cfg_data     <= {15'($urandom), pha};
        @(posedge clk);
        cfg_index    <= bsm_pkg::CFG_LSB_FIRST;
        cfg_data     <= {15'($urandom), lsb};
        @(posedge clk);
        cfg_index    <= bsm_pkg::CFG_HALF_PERIOD;
        cfg_data     <= hp;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input int n, input int idle_mode);
        int         sel;
        logic [7:0] b;
        case (idle_mode)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 68; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 68; end
            default: begin src_idle_pct = 10; snk_stall_pct = 10; end
        endcase
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(7);
            if (sel == 0)
                b = 8'h00;
            else if (sel == 1)
                b = 8'hFF;
            else
                b = 8'($urandom_range(255));
            send_word($urandom_range(2) == 0, b, 1'($urandom_range(1)),
                      $urandom_range(3) != 0);
            rand_words++;
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Shortest half period: a full byte of ones with a start while busy
        // and a missing tick in the middle.
        set_config(1'b0, 1'b0, 1'b0, 16'd0);
        send_word(1'b1, 8'hFF, 1'b0, 1'b1);
        for (int i = 0; i < 18; i++)
            send_word(i == 3, 8'h00, i[0], i != 5);
        drain();

        // Longest half period, then shortened below the running count.
        set_config(1'b1, 1'b0, 1'b1, 16'hFFFF);
        send_word(1'b1, 8'h00, 1'b1, 1'b1);
        for (int i = 0; i < 4; i++)
            send_word(1'b0, 8'hFF, 1'b1, 1'b1);
        drain();
        set_config(1'b1, 1'b0, 1'b1, 16'd2);
        send_word(1'b0, 8'h00, 1'b1, 1'b1);

        phase      = 0;
        rand_words = 0;
        while (rand_words < MIN_WORDS && phase < MAX_PHASES)
        begin
            drain();
            if (phase < 8)
                set_config(phase[0], phase[1], phase[2],
                           (phase % 5 == 4) ? 16'($urandom_range(6, 4))
                                            : 16'($urandom_range(3)));
            else
                set_config(1'($urandom_range(1)), 1'($urandom_range(1)),
                           1'($urandom_range(1)),
                           (phase % 5 == 4) ? 16'($urandom_range(6, 4))
                                            : 16'($urandom_range(3)));
            run_phase(80, phase % 4);
            phase++;
        end

        drain();
        repeat (10) @(posedge clk);
        $display("Sent %0d words in %0d random phases; %0d bytes were exchanged.",
                 words_sent, phase, bytes_done);
        $display("All SPI modes, both bit orders and half periods 0 to 65535 were used.");
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
